>>> rtl/core/ura_pkg.sv
// ----------------------------------------------------------------------------
// ura_pkg
// Shared constants and types for the ultrasonic range averager: sizes of the
// stores, conversion constants and operation codes.
// ----------------------------------------------------------------------------
package ura_pkg;

    // store geometry
    localparam int SENSORS       = 5;
    localparam int SAMPLES       = 5;
    localparam int TIMER_FREQ_HZ = 1000000;

    localparam int SAMP_DEPTH = SENSORS * SAMPLES;
    localparam int SAMP_AW    = (SAMP_DEPTH > 1) ? $clog2(SAMP_DEPTH) : 1;
    localparam int AVG_AW     = (SENSORS > 1) ? $clog2(SENSORS) : 1;
    localparam int SLOT_IDX_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
    localparam int CNT_W      = $clog2(SAMPLES + 1);
    localparam int SUM_W      = 16 + ((SAMPLES > 1) ? $clog2(SAMPLES) : 0);
    localparam int ADDR_CALC_W = 8;

    // field widths
    localparam int FUNC_W   = 2;
    localparam int SENSOR_W = 3;
    localparam int SLOT_W   = 3;
    localparam int DATA_W   = 16;
    localparam int MASK_W   = 5;
    localparam int TEMP_W   = 8;

    // configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_ENABLE = 1'b0;
    localparam logic REG_TEMP   = 1'b1;
    localparam logic [MASK_W-1:0] ENABLE_RESET = 5'd8;
    localparam logic [TEMP_W-1:0] TEMP_RESET   = 8'd22;

    // tick to microsecond scaling
    localparam int US_SCALE = 1000;
    localparam int TICK_DIV = TIMER_FREQ_HZ / 1000;
    localparam bit TICK_DIRECT = (TICK_DIV == US_SCALE);

    // shared divider
    localparam int DIVIDEND_W = 26;
    localparam int DIVISOR_W  = 17;

    // speed of sound in dm/s: a = 3313 + 6*T, a -= (a/100)*17
    localparam int AIR_A_W    = 13;
    localparam int AIR_W      = 12;
    localparam int AIR_BASE   = 3313;
    localparam int AIR_SLOPE  = 6;
    localparam int AIR_CENT   = 100;
    localparam int AIR_CORR   = 17;
    localparam int MM_SCALE   = 1000;
    // a/100 by reciprocal, then one correction step
    localparam int CENT_RECIP = 5243;
    localparam int CENT_SHIFT = 19;
    localparam int CENT_Q_W   = 7;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_STORE   = 2'd0,
        FUNC_AVERAGE = 2'd1,
        FUNC_CLEAR   = 2'd2
    } func_t;

endpackage

>>> rtl/core/ultrasonic_range_averager.sv
// ----------------------------------------------------------------------------
// ultrasonic_range_averager
// Multi-channel ultrasonic ranging store: converts echo ticks to millimetres,
// keeps per-sensor samples and computes per-sensor averages.
// ----------------------------------------------------------------------------
// Usage:
//   A command is taken on a rising edge with start high and busy low. func
//   selects store sample, compute all averages or clear one sensor; code 3 is
//   taken and dropped with no result.
//   Results appear for one cycle with result_valid high; last marks the final
//   result of a command. The receiver cannot stall, so results are never held.
//   Store: the speed of sound is worked out from the temperature, then the
//   26-step serial divider converts the echo (a second divider pass is added
//   when the timer rate is not 1 MHz). An overflowed echo skips the conversion.
//   One result.
//   Average: per sensor, each sample slot is read in turn (one memory read
//   port) and the nonzero samples are summed; the sum is then divided by
//   their count if there are any. One result per sensor. Clear: one result.
//   One command is in flight at a time; busy stays high until its results
//   are out. Registers are to be written over the APB port while busy is
//   low; the block itself does not enforce this.
//   Reset: both stores read as zero (per-entry valid flags), enable_mask = 8,
//   temperature_c = 22; the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module ultrasonic_range_averager (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ura_pkg::PADDR_W-1:0]       paddr,
    input  logic [ura_pkg::PDATA_W-1:0]       pwdata,
    output logic [ura_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready,
    // command channel
    input  logic                              start,
    output logic                              busy,
    input  logic [ura_pkg::FUNC_W-1:0]        func,
    input  logic [ura_pkg::SENSOR_W-1:0]      sensor,
    input  logic [ura_pkg::SLOT_W-1:0]        slot,
    input  logic [ura_pkg::DATA_W-1:0]        capture_ticks,
    input  logic                              overflow,
    // result channel
    output logic                              result_valid,
    output logic [ura_pkg::SENSOR_W-1:0]      sensor_out,
    output logic [ura_pkg::DATA_W-1:0]        distance_mm,
    output logic [ura_pkg::DATA_W-1:0]        average_mm,
    output logic                              average_updated,
    output logic                              last
);
    import ura_pkg::*;

    typedef enum logic [15:0] {
        S_IDLE     = 16'b0000_0000_0000_0001,
        S_AIR_A    = 16'b0000_0000_0000_0010,
        S_AIR_Q    = 16'b0000_0000_0000_0100,
        S_AIR_FIX  = 16'b0000_0000_0000_1000,
        S_US_GO    = 16'b0000_0000_0001_0000,
        S_US_WAIT  = 16'b0000_0000_0010_0000,
        S_MM_GO    = 16'b0000_0000_0100_0000,
        S_MM_WAIT  = 16'b0000_0000_1000_0000,
        S_ST_WR    = 16'b0000_0001_0000_0000,
        S_ST_OUT   = 16'b0000_0010_0000_0000,
        S_CLR      = 16'b0000_0100_0000_0000,
        S_AVG_RD   = 16'b0000_1000_0000_0000,
        S_AVG_ACC  = 16'b0001_0000_0000_0000,
        S_AVG_DEC  = 16'b0010_0000_0000_0000,
        S_AVG_WAIT = 16'b0100_0000_0000_0000,
        S_AVG_NEXT = 16'b1000_0000_0000_0000
    } state_t;

    // control state
    state_t                state_reg, state_next;
    logic [MASK_W-1:0]     enable_reg, enable_next;
    logic [TEMP_W-1:0]     temp_reg, temp_next;
    logic [SAMP_DEPTH-1:0] samp_vld_reg, samp_vld_next;
    logic [SENSORS-1:0]    avg_vld_reg, avg_vld_next;
    logic                  result_valid_reg, result_valid_next;

    // command and working registers
    logic [SENSOR_W-1:0]   sensor_reg, sensor_next;
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic [DATA_W-1:0]     ticks_reg, ticks_next;
    logic [AIR_A_W-1:0]    air_a_reg, air_a_next;
    logic [CENT_Q_W-1:0]   cent_q_reg, cent_q_next;
    logic [AIR_W-1:0]      air_reg, air_next;
    logic [DATA_W-1:0]     us_reg, us_next;
    logic [DATA_W-1:0]     mm_reg, mm_next;
    logic [SENSOR_W-1:0]   walk_s_reg, walk_s_next;
    logic [SLOT_IDX_W-1:0] walk_j_reg, walk_j_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;

    // result registers
    logic [SENSOR_W-1:0]   out_sensor_reg, out_sensor_next;
    logic [DATA_W-1:0]     out_dist_reg, out_dist_next;
    logic [DATA_W-1:0]     out_avg_reg, out_avg_next;
    logic                  out_upd_reg, out_upd_next;
    logic                  out_last_reg, out_last_next;

    // memories
    logic [DATA_W-1:0]     samp_mem [SAMP_DEPTH];
    logic [DATA_W-1:0]     avg_mem [SENSORS];
    logic                  samp_we, samp_re, avg_we, avg_re;
    logic [SAMP_AW-1:0]    samp_waddr, samp_raddr;
    logic [AVG_AW-1:0]     avg_waddr, avg_raddr;
    logic [DATA_W-1:0]     samp_wdata, avg_wdata;
    logic [DATA_W-1:0]     samp_rdata_reg, avg_rdata_reg;
    logic                  samp_rvld_reg, avg_rvld_reg;
    logic [DATA_W-1:0]     samp_rd, avg_rd;

    // divider
    logic                  div_start;
    logic [DIVIDEND_W-1:0] div_dividend;
    logic [DIVISOR_W-1:0]  div_divisor;
    logic [DIVIDEND_W-1:0] div_quotient;
    logic                  div_done;

    // helpers
    logic                  apb_write;
    logic                  sensor_ok, slot_ok, sensor_en;
    logic [ADDR_CALC_W-1:0] item_addr, walk_addr, row_base;
    logic [MASK_W-1:0]     en_shift;
    logic [2*AIR_A_W-1:0]  cent_prod;
    logic [AIR_A_W-1:0]    cent_rem;
    logic [CENT_Q_W-1:0]   cent_q_fix;
    logic                  walk_last_s, walk_last_j;

    assign apb_write = psel & penable & pwrite;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_TEMP) ? PDATA_W'(temp_reg) : PDATA_W'(enable_reg);

    assign busy = (state_reg != S_IDLE);

    // item decode
    assign sensor_ok = ({1'b0, sensor_reg} < (SENSOR_W + 1)'(SENSORS));
    assign slot_ok   = ({2'b0, slot_reg} < (SLOT_W + 2)'(SAMPLES));
    assign en_shift  = enable_reg >> sensor_reg;
    assign sensor_en = en_shift[0];
    assign row_base  = ADDR_CALC_W'(ADDR_CALC_W'(sensor_reg) * SAMPLES);
    assign item_addr = row_base + ADDR_CALC_W'(slot_reg);
    assign walk_addr = ADDR_CALC_W'(ADDR_CALC_W'(walk_s_reg) * SAMPLES)
                     + ADDR_CALC_W'(walk_j_reg);
    assign walk_last_s = (walk_s_reg == SENSOR_W'(SENSORS - 1));
    assign walk_last_j = (walk_j_reg == SLOT_IDX_W'(SAMPLES - 1));

    // entries never written since reset or clear read as zero
    assign samp_rd = samp_rvld_reg ? samp_rdata_reg : '0;
    assign avg_rd  = avg_rvld_reg ? avg_rdata_reg : '0;

    // hundreds of a, with a single correction step
    assign cent_prod  = (2*AIR_A_W)'(air_a_reg) * (2*AIR_A_W)'(CENT_RECIP);
    assign cent_rem   = air_a_reg - AIR_A_W'(cent_q_reg * AIR_A_W'(AIR_CENT));
    assign cent_q_fix = cent_q_reg + CENT_Q_W'(cent_rem >= AIR_A_W'(AIR_CENT));

    // divider operand selection
    always_comb
    begin
        case (state_reg)
            S_US_GO:
            begin
                div_dividend = DIVIDEND_W'(ticks_reg) * DIVIDEND_W'(US_SCALE);
                div_divisor  = DIVISOR_W'(TICK_DIV);
            end
            S_MM_GO:
            begin
                div_dividend = DIVIDEND_W'(us_reg) * DIVIDEND_W'(MM_SCALE);
                div_divisor  = DIVISOR_W'(air_reg);
            end
            default:
            begin
                div_dividend = DIVIDEND_W'(sum_reg);
                div_divisor  = DIVISOR_W'(cnt_reg);
            end
        endcase
    end

    ura_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .done     (div_done)
    );

    // command sequencer
    always_comb
    begin
        state_next        = state_reg;
        enable_next       = enable_reg;
        temp_next         = temp_reg;
        samp_vld_next     = samp_vld_reg;
        avg_vld_next      = avg_vld_reg;
        result_valid_next = 1'b0;
        sensor_next       = sensor_reg;
        slot_next         = slot_reg;
        ticks_next        = ticks_reg;
        air_a_next        = air_a_reg;
        cent_q_next       = cent_q_reg;
        air_next          = air_reg;
        us_next           = us_reg;
        mm_next           = mm_reg;
        walk_s_next       = walk_s_reg;
        walk_j_next       = walk_j_reg;
        sum_next          = sum_reg;
        cnt_next          = cnt_reg;
        out_sensor_next   = out_sensor_reg;
        out_dist_next     = out_dist_reg;
        out_avg_next      = out_avg_reg;
        out_upd_next      = out_upd_reg;
        out_last_next     = out_last_reg;
        div_start         = 1'b0;
        samp_we           = 1'b0;
        samp_re           = 1'b0;
        samp_waddr        = item_addr[SAMP_AW-1:0];
        samp_raddr        = walk_addr[SAMP_AW-1:0];
        samp_wdata        = mm_reg;
        avg_we            = 1'b0;
        avg_re            = 1'b0;
        avg_waddr         = walk_s_reg[AVG_AW-1:0];
        avg_raddr         = walk_s_reg[AVG_AW-1:0];
        avg_wdata         = div_quotient[DATA_W-1:0];

        // register writes over the configuration port
        if (apb_write)
        begin
            if (paddr[2] == REG_TEMP)
                temp_next = pwdata[TEMP_W-1:0];
            else
                enable_next = pwdata[MASK_W-1:0];
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    sensor_next = sensor;
                    slot_next   = slot;
                    ticks_next  = capture_ticks;
                    walk_s_next = '0;
                    walk_j_next = '0;
                    sum_next    = '0;
                    cnt_next    = '0;
                    case (func_t'(func))
                        FUNC_STORE:
                        begin
                            if (overflow)
                            begin
                                mm_next    = '0;
                                state_next = S_ST_WR;
                            end
                            else
                                state_next = S_AIR_A;
                        end
                        FUNC_AVERAGE: state_next = S_AVG_RD;
                        FUNC_CLEAR:   state_next = S_CLR;
                        default:      state_next = S_IDLE;
                    endcase
                end
            end

            // speed of sound from temperature
            S_AIR_A:
            begin
                air_a_next = AIR_A_W'(AIR_BASE) + AIR_A_W'(temp_reg) * AIR_A_W'(AIR_SLOPE);
                state_next = S_AIR_Q;
            end
            S_AIR_Q:
            begin
                cent_q_next = cent_prod[CENT_SHIFT + CENT_Q_W - 1:CENT_SHIFT];
                state_next  = S_AIR_FIX;
            end
            S_AIR_FIX:
            begin
                air_next = AIR_W'(air_a_reg - AIR_A_W'(cent_q_fix * AIR_A_W'(AIR_CORR)));
                if (TICK_DIRECT)
                begin
                    us_next    = ticks_reg;
                    state_next = S_MM_GO;
                end
                else
                    state_next = S_US_GO;
            end

            // ticks to microseconds, low 16 bits kept
            S_US_GO:
            begin
                div_start  = 1'b1;
                state_next = S_US_WAIT;
            end
            S_US_WAIT:
            begin
                if (div_done)
                begin
                    us_next    = div_quotient[DATA_W-1:0];
                    state_next = S_MM_GO;
                end
            end

            // microseconds to millimetres, halved for the round trip
            S_MM_GO:
            begin
                div_start  = 1'b1;
                state_next = S_MM_WAIT;
            end
            S_MM_WAIT:
            begin
                if (div_done)
                begin
                    mm_next    = div_quotient[DATA_W:1];
                    state_next = S_ST_WR;
                end
            end

            // sample write-back and average lookup
            S_ST_WR:
            begin
                if (sensor_ok && slot_ok && sensor_en)
                begin
                    samp_we                                = 1'b1;
                    samp_vld_next[item_addr[SAMP_AW-1:0]] = 1'b1;
                end
                avg_re     = 1'b1;
                avg_raddr  = sensor_reg[AVG_AW-1:0];
                state_next = S_ST_OUT;
            end
            S_ST_OUT:
            begin
                result_valid_next = 1'b1;
                out_sensor_next   = sensor_reg;
                out_dist_next     = mm_reg;
                out_avg_next      = sensor_ok ? avg_rd : '0;
                out_upd_next      = 1'b0;
                out_last_next     = 1'b1;
                state_next        = S_IDLE;
            end

            // clear one sensor row, its average and its enable bit
            S_CLR:
            begin
                if (sensor_ok)
                begin
                    for (int j = 0; j < SAMPLES; j++)
                        samp_vld_next[SAMP_AW'(row_base + ADDR_CALC_W'(j))] = 1'b0;
                    avg_vld_next[sensor_reg[AVG_AW-1:0]] = 1'b0;
                    enable_next = enable_reg & ~(MASK_W'(1) << sensor_reg);
                end
                result_valid_next = 1'b1;
                out_sensor_next   = sensor_reg;
                out_dist_next     = '0;
                out_avg_next      = '0;
                out_upd_next      = 1'b0;
                out_last_next     = 1'b1;
                state_next        = S_IDLE;
            end

            // walk the samples of one sensor
            S_AVG_RD:
            begin
                samp_re    = 1'b1;
                avg_re     = 1'b1;
                state_next = S_AVG_ACC;
            end
            S_AVG_ACC:
            begin
                if (samp_rd != '0)
                begin
                    sum_next = sum_reg + SUM_W'(samp_rd);
                    cnt_next = cnt_reg + 1'b1;
                end
                if (walk_last_j)
                    state_next = S_AVG_DEC;
                else
                begin
                    walk_j_next = walk_j_reg + 1'b1;
                    state_next  = S_AVG_RD;
                end
            end
            S_AVG_DEC:
            begin
                if (cnt_reg != '0)
                begin
                    div_start  = 1'b1;
                    state_next = S_AVG_WAIT;
                end
                else
                begin
                    // no nonzero samples: old average stands
                    result_valid_next = 1'b1;
                    out_sensor_next   = walk_s_reg;
                    out_dist_next     = '0;
                    out_avg_next      = avg_rd;
                    out_upd_next      = 1'b0;
                    out_last_next     = walk_last_s;
                    state_next        = S_AVG_NEXT;
                end
            end
            S_AVG_WAIT:
            begin
                if (div_done)
                begin
                    avg_we                                  = 1'b1;
                    avg_vld_next[walk_s_reg[AVG_AW-1:0]] = 1'b1;
                    result_valid_next = 1'b1;
                    out_sensor_next   = walk_s_reg;
                    out_dist_next     = '0;
                    out_avg_next      = div_quotient[DATA_W-1:0];
                    out_upd_next      = 1'b1;
                    out_last_next     = walk_last_s;
                    state_next        = S_AVG_NEXT;
                end
            end
            S_AVG_NEXT:
            begin
                if (walk_last_s)
                    state_next = S_IDLE;
                else
                begin
                    walk_s_next = walk_s_reg + 1'b1;
                    walk_j_next = '0;
                    sum_next    = '0;
                    cnt_next    = '0;
                    state_next  = S_AVG_RD;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            enable_reg       <= ENABLE_RESET;
            temp_reg         <= TEMP_RESET;
            samp_vld_reg     <= '0;
            avg_vld_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            enable_reg       <= enable_next;
            temp_reg         <= temp_next;
            samp_vld_reg     <= samp_vld_next;
            avg_vld_reg      <= avg_vld_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // working and result registers
    always_ff @(posedge clk)
    begin
        sensor_reg     <= sensor_next;
        slot_reg       <= slot_next;
        ticks_reg      <= ticks_next;
        air_a_reg      <= air_a_next;
        cent_q_reg     <= cent_q_next;
        air_reg        <= air_next;
        us_reg         <= us_next;
        mm_reg         <= mm_next;
        walk_s_reg     <= walk_s_next;
        walk_j_reg     <= walk_j_next;
        sum_reg        <= sum_next;
        cnt_reg        <= cnt_next;
        out_sensor_reg <= out_sensor_next;
        out_dist_reg   <= out_dist_next;
        out_avg_reg    <= out_avg_next;
        out_upd_reg    <= out_upd_next;
        out_last_reg   <= out_last_next;
    end

    // sample store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (samp_we)
            samp_mem[samp_waddr] <= samp_wdata;
        if (samp_re)
        begin
            samp_rdata_reg <= samp_mem[samp_raddr];
            samp_rvld_reg  <= samp_vld_reg[samp_raddr];
        end
    end

    // average store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (avg_we)
            avg_mem[avg_waddr] <= avg_wdata;
        if (avg_re)
        begin
            avg_rdata_reg <= avg_mem[avg_raddr];
            avg_rvld_reg  <= avg_vld_reg[avg_raddr];
        end
    end

    assign result_valid    = result_valid_reg;
    assign sensor_out      = out_sensor_reg;
    assign distance_mm     = out_dist_reg;
    assign average_mm      = out_avg_reg;
    assign average_updated = out_upd_reg;
    assign last            = out_last_reg;

endmodule

>>> rtl/core/ura_divider.sv
// ----------------------------------------------------------------------------
// ura_divider
// Restoring radix-2 divider, one quotient bit per cycle. Used for the tick
// scaling, the millimetre conversion and the per-sensor mean.
// ----------------------------------------------------------------------------
module ura_divider (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [ura_pkg::DIVIDEND_W-1:0]    dividend,
    input  logic [ura_pkg::DIVISOR_W-1:0]     divisor,
    output logic [ura_pkg::DIVIDEND_W-1:0]    quotient,
    output logic                              done
);
    import ura_pkg::*;

    localparam int STEP_W = $clog2(DIVIDEND_W + 1);

    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dsr_reg, dsr_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic                  done_reg, done_next;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    // trial subtraction of one step
    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = (trial >= {1'b0, dsr_reg});

    // step control
    always_comb
    begin
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            dsr_next  = divisor;
            quo_next  = dividend;
            step_next = STEP_W'(DIVIDEND_W);
        end
        else if (step_reg != '0)
        begin
            rem_next  = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            quo_next  = {quo_reg[DIVIDEND_W-2:0], fits};
            step_next = step_reg - 1'b1;
            done_next = (step_reg == STEP_W'(1));
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule
